/* sv/uaet_pkg.sv */
// Package for the unverified admission evict table.
// Holds the transaction structs, opcode/status/state enums and defaults.
// No dependencies.
`default_nettype none
package uaet_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int KEY_BITS_DEF      = 64;
	localparam int CAP_W             = 6;
	localparam logic [CAP_W-1:0] TOTAL_CAP_RST  = 6'd16;
	localparam logic [CAP_W-1:0] SENDER_CAP_RST = 6'd8;

	// configuration register indexes
	localparam logic CFG_TOTAL_CAP  = 1'b0;
	localparam logic CFG_SENDER_CAP = 1'b1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SETVER = 2'd2,
		OP_NONE   = 2'd3
	} uaet_op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_UPDATED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5,
		ST_NO_VICTIM = 3'd6
	} uaet_status_t;

	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PICK,
		S_EVICT
	} uaet_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] message_key;
		logic [63:0] sender_key;
		logic        verified;
	} uaet_req_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [63:0] evicted_key;
		logic        last;
	} uaet_rsp_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic clr;     // clear match counter and seen flag
		logic step;    // compare against the probe this cycle
		logic earlier; // probe index is below this cell
		logic shift;   // take the neighbor's entry
		logic load;    // take the new entry
		logic setver;  // overwrite the verified flag
	} uaet_cell_ctl_t;

endpackage
`default_nettype wire

/* sv/uaet_cell.sv */
// One slot of the table: entry storage plus sender match counter.
// Depends on uaet_pkg.
`default_nettype none
module uaet_cell #(
	parameter int KEY_BITS = uaet_pkg::KEY_BITS_DEF,
	parameter int CW       = 6
) (
	input  wire logic                    clk,
	input  wire uaet_pkg::uaet_cell_ctl_t ctl,
	input  wire logic [KEY_BITS-1:0]     nxt_key,
	input  wire logic [KEY_BITS-1:0]     nxt_sender,
	input  wire logic                    nxt_ver,
	input  wire logic [KEY_BITS-1:0]     new_key,
	input  wire logic [KEY_BITS-1:0]     new_sender,
	input  wire logic                    new_ver,
	input  wire logic [KEY_BITS-1:0]     probe_sender,
	input  wire logic                    probe_unv,
	output logic [KEY_BITS-1:0]          key,
	output logic [KEY_BITS-1:0]          sender,
	output logic                         ver,
	output logic [CW-1:0]                cnt,
	output logic                         seen
);
	logic [KEY_BITS-1:0] key_q, sender_q;
	logic                ver_q, seen_q;
	logic [CW-1:0]       cnt_q;
	logic                hit;

	assign hit = ctl.step && probe_unv && (probe_sender == sender_q);

	// entry storage: load, compaction shift, flag update
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q    <= new_key;
			sender_q <= new_sender;
			ver_q    <= new_ver;
		end else if (ctl.shift) begin
			key_q    <= nxt_key;
			sender_q <= nxt_sender;
			ver_q    <= nxt_ver;
		end else if (ctl.setver) begin
			ver_q <= new_ver;
		end
	end

	// unverified same-sender count and earlier-sender flag
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			cnt_q  <= '0;
			seen_q <= 1'b0;
		end else if (hit) begin
			cnt_q <= cnt_q + CW'(1);
			if (ctl.earlier) begin
				seen_q <= 1'b1;
			end
		end
	end

	assign key    = key_q;
	assign sender = sender_q;
	assign ver    = ver_q;
	assign cnt    = cnt_q;
	assign seen   = seen_q;
endmodule
`default_nettype wire

/* sv/unverified_admission_evict_table.sv */
// Top level: sequencer over a row of uaet_cell slots.
// Depends on uaet_pkg and uaet_cell.
//
//  channel | signals                      | payload
//  req     | req_valid / req_ready        | uaet_req_t  (operation, keys, verified)
//  rsp     | rsp_valid / rsp_ready        | uaet_rsp_t  (kind, status, evicted_key, last)
//  cfg     | cfg_we, cfg_index            | cfg_data (6-bit cap)
//
// One request at a time. After the accept cycle a scan pass visits each stored
// entry in turn, then the decision state writes the status. Each eviction adds
// a victim pass over the entries, an eviction state and a fresh scan.
// Reset empties the table and loads the cap defaults; no clearing pass.
// A full result register stalls the sequencer until rsp_ready frees it.
`default_nettype none
module unverified_admission_evict_table #(
	parameter int TABLE_ENTRIES = uaet_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BITS      = uaet_pkg::KEY_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_ready,
	input  wire uaet_pkg::uaet_req_t     req,
	output logic                         rsp_valid,
	input  wire logic                    rsp_ready,
	output uaet_pkg::uaet_rsp_t          rsp,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [uaet_pkg::CAP_W-1:0] cfg_data
);
	localparam int N  = TABLE_ENTRIES;
	localparam int CW = $clog2(N + 1);
	localparam int IW = $clog2(N);
	localparam int MW = (CW > uaet_pkg::CAP_W) ? CW : uaet_pkg::CAP_W;

	uaet_pkg::uaet_state_t state_q, state_d;

	logic [CW-1:0]       count_q, j_q, total_q, distinct_q, best_q;
	logic [IW-1:0]       slot_q, victim_q, jidx;
	logic [uaet_pkg::CAP_W-1:0] cap0_q, cap1_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q, sender_q;
	logic                ver_q, found_q, known_q;
	logic                rsp_valid_q;
	uaet_pkg::uaet_rsp_t rsp_q;

	// cell row wiring
	logic [KEY_BITS-1:0] key_w [N];
	logic [KEY_BITS-1:0] snd_w [N];
	logic                ver_w [N];
	logic [CW-1:0]       cnt_w [N];
	logic                seen_w [N];

	// sequencer outputs
	logic                accept, out_free, j_live, caps_ok, full;
	logic                emit, emit_kind;
	uaet_pkg::uaet_status_t emit_status;
	logic [63:0]         emit_key;
	logic                load_en, del_en, setv_en, clr_en, scan_step, pick_step, pick_start;
	logic [IW-1:0]       del_slot;
	logic [KEY_BITS-1:0] pj_key, pj_snd;
	logic                pj_unv, pj_seen;
	logic [CW-1:0]       pj_cnt;

	assign accept   = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign jidx     = j_q[IW-1:0];
	assign j_live   = j_q < count_q;
	assign caps_ok  = (MW'(total_q) < MW'(cap0_q)) &&
	                  (known_q || (MW'(distinct_q) < MW'(cap1_q)));
	assign full     = count_q >= CW'(N);

	// probe read of entry j
	always_comb begin
		pj_key  = key_w[jidx];
		pj_snd  = snd_w[jidx];
		pj_unv  = !ver_w[jidx];
		pj_seen = seen_w[jidx];
		pj_cnt  = cnt_w[jidx];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			uaet_pkg::S_IDLE: begin
				if (accept && req.operation != uaet_pkg::OP_NONE) begin
					state_d = uaet_pkg::S_SCAN;
				end
			end
			uaet_pkg::S_SCAN: begin
				if (!j_live) begin
					state_d = uaet_pkg::S_DECIDE;
				end
			end
			uaet_pkg::S_DECIDE: begin
				if (out_free) begin
					if (op_q == uaet_pkg::OP_INSERT && !found_q && !ver_q && !caps_ok &&
					    total_q != '0) begin
						state_d = uaet_pkg::S_PICK;
					end else begin
						state_d = uaet_pkg::S_IDLE;
					end
				end
			end
			uaet_pkg::S_PICK: begin
				if (!j_live) begin
					state_d = uaet_pkg::S_EVICT;
				end
			end
			uaet_pkg::S_EVICT: begin
				if (out_free) begin
					state_d = uaet_pkg::S_SCAN;
				end
			end
			default: state_d = uaet_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready   = 1'b0;
		emit        = 1'b0;
		emit_kind   = uaet_pkg::KIND_FINAL;
		emit_status = uaet_pkg::ST_INSERTED;
		emit_key    = '0;
		load_en     = 1'b0;
		del_en      = 1'b0;
		del_slot    = slot_q;
		setv_en     = 1'b0;
		clr_en      = 1'b0;
		scan_step   = 1'b0;
		pick_step   = 1'b0;
		pick_start  = 1'b0;
		case (state_q)
			uaet_pkg::S_IDLE: begin
				req_ready = 1'b1;
				clr_en    = accept;
			end
			uaet_pkg::S_SCAN: begin
				scan_step = j_live;
			end
			uaet_pkg::S_DECIDE: begin
				if (out_free) begin
					emit = 1'b1;
					case (op_q)
						uaet_pkg::OP_INSERT: begin
							if (found_q) begin
								emit_status = uaet_pkg::ST_DUPLICATE;
							end else if (ver_q || caps_ok) begin
								if (full) begin
									emit_status = uaet_pkg::ST_FULL;
								end else begin
									emit_status = uaet_pkg::ST_INSERTED;
									load_en     = 1'b1;
								end
							end else if (total_q == '0) begin
								emit_status = uaet_pkg::ST_NO_VICTIM;
							end else begin
								emit       = 1'b0;
								pick_start = 1'b1;
							end
						end
						uaet_pkg::OP_REMOVE: begin
							if (found_q) begin
								emit_status = uaet_pkg::ST_REMOVED;
								del_en      = 1'b1;
							end else begin
								emit_status = uaet_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
							if (found_q) begin
								emit_status = uaet_pkg::ST_UPDATED;
								setv_en     = 1'b1;
							end else begin
								emit_status = uaet_pkg::ST_NOT_FOUND;
							end
						end
					endcase
				end
			end
			uaet_pkg::S_PICK: begin
				pick_step = j_live;
			end
			uaet_pkg::S_EVICT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_kind   = uaet_pkg::KIND_EVICT;
					emit_status = uaet_pkg::ST_REMOVED;
					emit_key    = 64'(key_w[victim_q]);
					del_en      = 1'b1;
					del_slot    = victim_q;
					clr_en      = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uaet_pkg::S_IDLE;
			count_q     <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
			cap0_q      <= uaet_pkg::TOTAL_CAP_RST;
			cap1_q      <= uaet_pkg::SENDER_CAP_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == uaet_pkg::CFG_TOTAL_CAP) begin
				cap0_q <= cfg_data;
			end
			if (cfg_we && cfg_index == uaet_pkg::CFG_SENDER_CAP) begin
				cap1_q <= cfg_data;
			end
			if (load_en) begin
				count_q <= count_q + CW'(1);
			end else if (del_en) begin
				count_q <= count_q - CW'(1);
			end
			if (clr_en || pick_start) begin
				j_q <= '0;
			end else if (scan_step || pick_step) begin
				j_q <= j_q + CW'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request latch, scan accumulators, victim search, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.operation;
			key_q    <= req.message_key[KEY_BITS-1:0];
			sender_q <= req.sender_key[KEY_BITS-1:0];
			ver_q    <= req.verified;
		end
		if (clr_en) begin
			found_q    <= 1'b0;
			known_q    <= 1'b0;
			total_q    <= '0;
			distinct_q <= '0;
		end else if (scan_step) begin
			if (!found_q && pj_key == key_q) begin
				found_q <= 1'b1;
				slot_q  <= jidx;
			end
			if (pj_unv) begin
				total_q <= total_q + CW'(1);
				if (!pj_seen) begin
					distinct_q <= distinct_q + CW'(1);
				end
				if (pj_snd == sender_q) begin
					known_q <= 1'b1;
				end
			end
		end
		if (pick_start) begin
			best_q <= '0;
		end else if (pick_step && pj_unv && pj_cnt > best_q) begin
			best_q   <= pj_cnt;
			victim_q <= jidx;
		end
		if (emit) begin
			rsp_q.kind        <= emit_kind;
			rsp_q.status      <= emit_status;
			rsp_q.evicted_key <= emit_key;
			rsp_q.last        <= emit_kind;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// row of cells; each shifts in from its right neighbor on compaction
	for (genvar i = 0; i < N; i++) begin : g_cell
		uaet_pkg::uaet_cell_ctl_t ctl;
		localparam int NX = (i == N - 1) ? i : i + 1;
		always_comb begin
			ctl.clr     = clr_en;
			ctl.step    = scan_step;
			ctl.earlier = j_q < CW'(i);
			ctl.shift   = del_en && (CW'(i) >= CW'(del_slot));
			ctl.load    = load_en && (count_q == CW'(i));
			ctl.setver  = setv_en && (slot_q == IW'(i));
		end
		uaet_cell #(
			.KEY_BITS(KEY_BITS),
			.CW      (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.nxt_key     (key_w[NX]),
			.nxt_sender  (snd_w[NX]),
			.nxt_ver     (ver_w[NX]),
			.new_key     (key_q),
			.new_sender  (sender_q),
			.new_ver     (ver_q),
			.probe_sender(pj_snd),
			.probe_unv   (pj_unv),
			.key         (key_w[i]),
			.sender      (snd_w[i]),
			.ver         (ver_w[i]),
			.cnt         (cnt_w[i]),
			.seen        (seen_w[i])
		);
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("entry count above table size");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result written over a pending transaction");
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation != uaet_pkg::OP_NONE) |=> state_q == uaet_pkg::S_SCAN)
		else $error("request did not start a scan");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_kind == uaet_pkg::KIND_FINAL) |=> state_q == uaet_pkg::S_IDLE)
		else $error("final status without return to idle");
	a_evict_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == uaet_pkg::S_EVICT && out_free) |=> count_q == $past(count_q) - CW'(1))
		else $error("eviction did not drop an entry");
endmodule
`default_nettype wire
